### src/radix_integer_to_ascii_top_assert.svh
// Assertion macros shared by the converter modules.
`ifndef RADIX_INTEGER_TO_ASCII_TOP_ASSERT_SVH
`define RADIX_INTEGER_TO_ASCII_TOP_ASSERT_SVH

// Same-cycle implication, checked while out of reset.
`define RIA_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ria assertion failed");

// Next-cycle implication, checked while out of reset.
`define RIA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ria assertion failed");

`endif

### src/ria_pkg.sv
`default_nettype none

package ria_pkg;

    localparam logic [1:0] BASE_BIN = 2'd0;
    localparam logic [1:0] BASE_OCT = 2'd1;
    localparam logic [1:0] BASE_DEC = 2'd2;
    localparam logic [1:0] BASE_HEX = 2'd3;

    localparam logic [7:0] NO_PREFIX = 8'h20;

    localparam logic [7:0] DIGIT_CHARS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_CONV = 5'b00010,
        S_PREP = 5'b00100,
        S_SIGN = 5'b01000,
        S_EMIT = 5'b10000
    } t_state;

    typedef struct packed {
        logic load;
        logic shift;
        logic emit_start;
        logic emit_next;
    } t_row_ctrl;

    typedef struct packed {
        logic [3:0] digit;
        logic       last;
    } t_row_stat;

    function automatic logic [4:0] radix_of(input logic [1:0] base);
        logic [4:0] r;
        unique case (base)
            BASE_BIN: r = 5'd2;
            BASE_OCT: r = 5'd8;
            BASE_DEC: r = 5'd10;
            BASE_HEX: r = 5'd16;
            default:  r = 5'd16;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### src/ria_digit_row.sv
`default_nettype none

module ria_digit_row #(
    parameter int NCELL = 32
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic [1:0]        i_base,
    input  wire logic              i_bit,
    input  wire ria_pkg::t_row_ctrl i_ctrl,
    output ria_pkg::t_row_stat     o_stat
);
    import ria_pkg::*;

    `include "radix_integer_to_ascii_top_assert.svh"

    logic [3:0]       r_cell [NCELL];
    logic [3:0]       n_cell [NCELL];
    logic [NCELL-1:0] r_top, n_top;
    logic [NCELL-1:0] r_sel, n_sel;
    logic [NCELL-1:0] carry;
    logic [NCELL-1:0] cin;
    logic [4:0]       radix;
    logic [3:0]       half;
    logic             top_hit;
    logic [3:0]       digit;

    assign radix = radix_of(i_base);
    assign half  = radix[4:1];

    // Carry out of a cell depends only on its own value: 2d + c >= radix iff d >= radix/2.
    always_comb begin
        for (int i = 0; i < NCELL; i++) begin
            carry[i] = (r_cell[i] >= half);
        end
    end

    // Cell 0 takes the incoming bit, every other cell the carry of the one below.
    assign cin = {carry[NCELL-2:0], i_bit};

    assign top_hit = |(r_top & carry);

    always_comb begin
        logic [4:0] t;
        for (int i = 0; i < NCELL; i++) begin
            t = {r_cell[i], cin[i]};
            if (i_ctrl.load) begin
                n_cell[i] = 4'd0;
            end else if (i_ctrl.shift) begin
                n_cell[i] = carry[i] ? 4'(t - radix) : t[3:0];
            end else begin
                n_cell[i] = r_cell[i];
            end
        end
    end

    always_comb begin
        n_top = r_top;
        n_sel = r_sel;
        if (i_ctrl.load) begin
            n_top = NCELL'(1);
        end else if (i_ctrl.shift && top_hit) begin
            n_top = r_top << 1;
        end
        if (i_ctrl.emit_start) begin
            n_sel = r_top;
        end else if (i_ctrl.emit_next) begin
            n_sel = r_sel >> 1;
        end
    end

    always_comb begin
        digit = 4'd0;
        for (int i = 0; i < NCELL; i++) begin
            digit = digit | (r_cell[i] & {4{r_sel[i]}});
        end
    end

    assign o_stat.digit = digit;
    assign o_stat.last  = r_sel[0];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < NCELL; i++) begin
            r_cell[i] <= n_cell[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top <= NCELL'(1);
            r_sel <= '0;
        end else begin
            r_top <= n_top;
            r_sel <= n_sel;
        end
    end

    `RIA_ASSERT_NOW(a_top_onehot, i_clk, i_rst_n, 1'b1, $onehot(r_top))
    `RIA_ASSERT_NOW(a_sel_live, i_clk, i_rst_n, i_ctrl.emit_next, $onehot(r_sel))
    `RIA_ASSERT_NEXT(a_top_grow, i_clk, i_rst_n,
        i_ctrl.shift && !i_ctrl.load && top_hit, r_top == ($past(r_top) << 1))

endmodule

`default_nettype wire

### src/ria_out_reg.sv
`default_nettype none

module ria_out_reg (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_char,
    input  wire logic       i_last,
    output logic            o_can_push,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_char,
    output logic            o_last
);
    logic       r_valid;
    logic [7:0] r_char;
    logic       r_last;

    assign o_can_push = !r_valid || i_ready;
    assign o_valid    = r_valid;
    assign o_char     = r_char;
    assign o_last     = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_can_push) begin
            r_valid <= i_push;
        end
    end

    // Hold payload while the receiver stalls.
    always_ff @(posedge i_clk) begin
        if (o_can_push && i_push) begin
            r_char <= i_char;
            r_last <= i_last;
        end
    end

endmodule

`default_nettype wire

### src/radix_integer_to_ascii_top.sv
// Integer to ASCII converter, radix 2, 8, 10 or 16.
// Input channel: i_valid / o_ready carry i_value, i_base_select and i_sign_char.
// Output channel: o_valid / i_ready carry o_char_out and o_last, one character
// per transaction: the prefix (unless it is a space), then the digits, most
// significant first, lower-case hex; o_last marks the final digit.
// One number is converted at a time. After a transaction the value is shifted
// MSB first, one bit per cycle, into a row of VW digit cells, where VW is
// VALUE_WIDTH capped at 32; a setup state (S_PREP) follows, then one character
// per cycle leaves while the receiver keeps i_ready high.
// o_ready rises again the cycle after the last digit enters the output
// register, even if that character is still waiting to be taken.
// A receiver stall holds the output register and pauses the digit stream.
// Reset (i_rst_n low, synchronous) drops any number in progress and any
// pending character.
`default_nettype none

module radix_integer_to_ascii_top #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_ready,
    input  wire logic [31:0] i_value,
    input  wire logic [1:0]  i_base_select,
    input  wire logic [7:0]  i_sign_char,
    output logic             o_valid,
    input  wire logic        i_ready,
    output logic [7:0]       o_char_out,
    output logic             o_last
);
    import ria_pkg::*;

    `include "radix_integer_to_ascii_top_assert.svh"

    localparam int VW = (VALUE_WIDTH > 32) ? 32 : VALUE_WIDTH;
    localparam int CW = $clog2(VW);

    t_state        r_state, n_state;
    logic [VW-1:0] r_val, n_val;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [1:0]    r_base, n_base;
    logic [7:0]    r_sign, n_sign;

    t_row_ctrl     row_ctrl;
    t_row_stat     row_stat;
    logic          can_push;
    logic          push;
    logic [7:0]    push_char;
    logic          push_last;
    logic          in_accept;

    assign o_ready   = (r_state == S_IDLE);
    assign in_accept = i_valid && o_ready;

    always_comb begin
        n_state   = r_state;
        n_val     = r_val;
        n_cnt     = r_cnt;
        n_base    = r_base;
        n_sign    = r_sign;
        row_ctrl  = '0;
        push      = 1'b0;
        push_char = DIGIT_CHARS[row_stat.digit];
        push_last = row_stat.last;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_val         = i_value[VW-1:0];
                    n_cnt         = CW'(VW - 1);
                    n_base        = i_base_select;
                    n_sign        = i_sign_char;
                    row_ctrl.load = 1'b1;
                    n_state       = S_CONV;
                end
            end
            S_CONV: begin
                row_ctrl.shift = 1'b1;
                n_val          = r_val << 1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                row_ctrl.emit_start = 1'b1;
                n_state = (r_sign != NO_PREFIX) ? S_SIGN : S_EMIT;
            end
            S_SIGN: begin
                push      = 1'b1;
                push_char = r_sign;
                push_last = 1'b0;
                if (can_push) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                push = 1'b1;
                if (can_push) begin
                    row_ctrl.emit_next = 1'b1;
                    if (row_stat.last) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_val  <= n_val;
        r_cnt  <= n_cnt;
        r_base <= n_base;
        r_sign <= n_sign;
    end

    ria_digit_row #(
        .NCELL (VW)
    ) u_row (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_base  (r_base),
        .i_bit   (r_val[VW-1]),
        .i_ctrl  (row_ctrl),
        .o_stat  (row_stat)
    );

    ria_out_reg u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (push),
        .i_char     (push_char),
        .i_last     (push_last),
        .o_can_push (can_push),
        .o_valid    (o_valid),
        .i_ready    (i_ready),
        .o_char     (o_char_out),
        .o_last     (o_last)
    );

    `RIA_ASSERT_NEXT(a_accept_conv, i_clk, i_rst_n, in_accept, r_state == S_CONV)
    `RIA_ASSERT_NEXT(a_last_idle, i_clk, i_rst_n,
        r_state == S_EMIT && can_push && row_stat.last, r_state == S_IDLE && o_valid && o_last)
    `RIA_ASSERT_NEXT(a_prep_out, i_clk, i_rst_n,
        r_state == S_PREP, r_state == S_SIGN || r_state == S_EMIT)

endmodule

`default_nettype wire

### test/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ria_pkg::*;

    localparam int NUM_NUMBERS = 470;
    localparam int QUIET_TAIL = 60;
    localparam int STALL_LIMIT = 3000;
    localparam int DRAIN_CYCLES = 80;

    typedef struct {
        logic [31:0] value;
        logic [1:0]  base;
        logic [7:0]  sign;
        int          gap_after;
        bit          wait_drained;
    } t_number_req;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_text_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_value = '0;
    logic [1:0]  i_base_select = BASE_BIN;
    logic [7:0]  i_sign_char = NO_PREFIX;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [7:0]  o_char_out;
    logic        o_last;

    t_number_req number_queue[$];
    t_text_char  text_expected[$];

    bit in_taken = 1'b0;
    int gap_left = 0;
    int stall_left = 0;
    int numbers_taken = 0;
    int bad_chars = 0;
    int quiet_cycles = 0;

    radix_integer_to_ascii_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_value       (i_value),
        .i_base_select (i_base_select),
        .i_sign_char   (i_sign_char),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_char_out    (o_char_out),
        .o_last        (o_last)
    );

    always #2 i_clk = ~i_clk;

    // Stretches with no idling on either side: one block in four, and the tail.
    function automatic bit is_quiet(input int idx);
        return (idx >= NUM_NUMBERS - QUIET_TAIL) || ((idx / 50) % 4 == 3);
    endfunction

    // Append the text of one number: optional prefix, then digits MSB first.
    function automatic void queue_text_of(input logic [31:0] value,
                                          input logic [1:0] base,
                                          input logic [7:0] sign);
        logic [3:0]  digit [32];
        logic [31:0] rest;
        logic [31:0] radix;
        logic [7:0]  ch;
        int          ndig;
        t_text_char  c;
        case (base)
            BASE_BIN: radix = 32'd2;
            BASE_OCT: radix = 32'd8;
            BASE_DEC: radix = 32'd10;
            default:  radix = 32'd16;
        endcase
        rest = value;
        ndig = 0;
        do begin
            digit[ndig] = 4'(rest % radix);
            ndig++;
            rest = rest / radix;
        end while (rest != 0 && ndig < 32);
        if (sign != NO_PREFIX) begin
            c.ch = sign;
            c.last = 1'b0;
            text_expected.push_back(c);
        end
        for (int i = ndig - 1; i >= 0; i--) begin
            // ASCII '0' for 0..9, 'a' - 10 for 10..15
            ch = (digit[i] < 4'd10) ? (8'h30 + {4'h0, digit[i]})
                                    : (8'h57 + {4'h0, digit[i]});
            c.ch = ch;
            c.last = (i == 0);
            text_expected.push_back(c);
        end
    endfunction

    task automatic add_number(input logic [31:0] value, input logic [1:0] base,
                              input logic [7:0] sign, input bit wait_drained);
        t_number_req r;
        r.value = value;
        r.base = base;
        r.sign = sign;
        r.wait_drained = wait_drained;
        r.gap_after = (!is_quiet(number_queue.size()) && $urandom_range(0, 3) == 0)
                      ? $urandom_range(1, 13) : 0;
        number_queue.push_back(r);
    endtask

    // Driver: present one number, hold it until the transaction completes.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !in_taken) begin
            // hold payload
        end else if (gap_left > 0) begin
            i_valid <= 1'b0;
            gap_left <= gap_left - 1;
        end else if (number_queue.size() == 0 ||
                     (number_queue[0].wait_drained && text_expected.size() != 0)) begin
            i_valid <= 1'b0;
        end else begin
            i_value <= number_queue[0].value;
            i_base_select <= number_queue[0].base;
            i_sign_char <= number_queue[0].sign;
            gap_left <= number_queue[0].gap_after;
            i_valid <= 1'b1;
            void'(number_queue.pop_front());
        end
    end

    // Receiver back-pressure in random bursts.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_ready <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            i_ready <= 1'b1;
            if (!is_quiet(numbers_taken) && $urandom_range(0, 5) == 0)
                stall_left <= $urandom_range(1, 13);
        end
    end

    // Monitor: check characters first, then record any new number.
    always @(posedge i_clk) begin
        t_text_char want;
        in_taken <= i_rst_n && i_valid && o_ready;
        if (i_rst_n && o_valid && i_ready) begin
            if (text_expected.size() == 0) begin
                bad_chars++;
                $display("%0t: unexpected char, expected none actual %02h last %0b",
                         $realtime, o_char_out, o_last);
            end else begin
                want = text_expected.pop_front();
                if (o_char_out !== want.ch) begin
                    bad_chars++;
                    $display("%0t: char mismatch, expected %02h actual %02h",
                             $realtime, want.ch, o_char_out);
                end
                if (o_last !== want.last) begin
                    bad_chars++;
                    $display("%0t: last mismatch, expected %0b actual %0b",
                             $realtime, want.last, o_last);
                end
            end
        end
        if (i_rst_n && i_valid && o_ready) begin
            queue_text_of(i_value, i_base_select, i_sign_char);
            numbers_taken++;
        end
    end

    // Watchdog: abort after too many cycles with no transaction on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        logic [31:0] v;
        logic [7:0]  s;
        int          pick;
        // zero in every radix, with and without prefix
        add_number(32'h0, BASE_BIN, NO_PREFIX, 1'b0);
        add_number(32'h0, BASE_OCT, "-", 1'b0);
        add_number(32'h0, BASE_DEC, "+", 1'b0);
        add_number(32'h0, BASE_HEX, NO_PREFIX, 1'b0);
        // all ones: the longest texts, binary with prefix is the worst case
        add_number(32'hFFFF_FFFF, BASE_BIN, "-", 1'b1);
        add_number(32'hFFFF_FFFF, BASE_OCT, NO_PREFIX, 1'b0);
        add_number(32'hFFFF_FFFF, BASE_DEC, NO_PREFIX, 1'b0);
        add_number(32'hFFFF_FFFF, BASE_HEX, "#", 1'b0);
        // odd prefixes: NUL, 0xff, above 127
        add_number(32'h1, BASE_DEC, 8'h00, 1'b0);
        add_number(32'h8000_0000, BASE_BIN, 8'hFF, 1'b0);
        add_number(32'h7FFF_FFFF, BASE_DEC, 8'h80, 1'b0);
        add_number(32'h5555_5555, BASE_BIN, 8'h7F, 1'b0);
        add_number(32'hAAAA_AAAA, BASE_HEX, NO_PREFIX, 1'b0);
        // digit roll-over boundaries
        add_number(32'd9, BASE_DEC, NO_PREFIX, 1'b1);
        add_number(32'd10, BASE_DEC, NO_PREFIX, 1'b0);
        add_number(32'd15, BASE_HEX, NO_PREFIX, 1'b0);
        add_number(32'd16, BASE_HEX, "-", 1'b0);
        add_number(32'd7, BASE_OCT, NO_PREFIX, 1'b0);
        add_number(32'd8, BASE_OCT, NO_PREFIX, 1'b0);
        add_number(32'd1, BASE_BIN, NO_PREFIX, 1'b0);
        add_number(32'd2, BASE_BIN, "+", 1'b0);

        while (number_queue.size() < NUM_NUMBERS) begin
            pick = $urandom_range(0, 3);
            case (pick)
                0: v = $urandom;
                1: v = $urandom >> $urandom_range(0, 31);
                2: v = $urandom_range(0, 20);
                default: v = (32'h1 << $urandom_range(0, 31)) - $urandom_range(0, 1);
            endcase
            if ($urandom_range(0, 1) == 0)
                s = NO_PREFIX;
            else if ($urandom_range(0, 3) == 0)
                s = 8'($urandom_range(0, 255));
            else
                s = "-";
            add_number(v, 2'($urandom_range(0, 3)), s, $urandom_range(0, 24) == 0);
        end

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (number_queue.size() != 0 || i_valid || text_expected.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_chars == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
